// ===== rtl/tspoc_pkg.sv =====
// Package for the transport packet output command generator.
// Holds field widths, header bit positions, register indexes and the chain link types.
// No dependencies.
package tspoc_pkg;

  // Default size of the remap table.
  localparam int REMAP_ENTRIES_DEF = 16;

  // Field widths.
  localparam int PID_W     = 13;
  localparam int INDEX_W   = 4;
  localparam int COUNT_W   = 24;
  localparam int CC_W      = 4;
  localparam int EXT_W     = 10;
  localparam int WORD_W    = 32;
  localparam int LIMIT_W   = 5;
  localparam int CFG_IDX_W = 3;

  // Header bit positions.
  localparam int PID_LSB       = 8;
  localparam int AF_EXISTS_BIT = 5;
  localparam int AF_LEN_LSB    = 24;
  localparam int PCR_FLAG_BIT  = 20;

  // Fixed marker in command word 0, bits 15:14.
  localparam logic [1:0] CMD_FIXED_BITS = 2'b10;

  // Value every remap entry holds after reset.
  localparam logic [PID_W-1:0] PID_RESET = PID_W'(16);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PCR_CORRECT_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PCR_OFFSET_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PCR_OFFSET_EXT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REMAP_COUNT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CC_RESTAMP_ENABLE  = 3'd4;

  // Input item opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  // Search query as it moves from cell to cell.
  typedef struct packed {
    logic             valid;
    logic [PID_W-1:0] pid;
    logic             hit;
    logic [PID_W-1:0] new_pid;
  } link_t;

  // Remap entry write, broadcast to every cell.
  typedef struct packed {
    logic               we;
    logic [INDEX_W-1:0] index;
    logic [PID_W-1:0]   match_pid;
    logic [PID_W-1:0]   replace_pid;
  } entry_wr_t;

endpackage

// ===== rtl/ts_packet_output_command_gen_top.sv =====
// Top level of the transport packet output command generator.
// Depends on tspoc_pkg and tspoc_chain.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: opcode 0 loads one
//   remap entry (entry_index, match_pid, replace_pid) and gives no result;
//   opcode 1 carries the first two header words of a transport packet and
//   gives one four-word command on the output channel (out_valid/out_ready).
//   A packet item walks the row of remap cells, one cell per cycle, and its
//   result is held until it can be loaded into the output register. One
//   item is in work at a time: the block takes no new item while a packet
//   item walks the row or waits for its command to be loaded.
//   The command sits in an output register; while it waits for out_ready the
//   block holds the next result and takes no further item until the register
//   frees. Configuration writes (cfg_write, cfg_index, cfg_data) take effect
//   at once; the user must make them only while the block is idle, and the
//   block itself does not enforce this.
//   Reset clears the counters, loads every remap entry with PID 16 and sets
//   the registers to their reset values; no clearing pass is needed.
module ts_packet_output_command_gen_top #(
  parameter int REMAP_ENTRIES = tspoc_pkg::REMAP_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration port.
  input  logic                            cfg_write,
  input  logic [tspoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tspoc_pkg::WORD_W-1:0]    cfg_data,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [tspoc_pkg::WORD_W-1:0]    header_word,
  input  logic [tspoc_pkg::WORD_W-1:0]    adaptation_word,
  input  logic [tspoc_pkg::INDEX_W-1:0]   entry_index,
  input  logic [tspoc_pkg::PID_W-1:0]     match_pid,
  input  logic [tspoc_pkg::PID_W-1:0]     replace_pid,
  // Output channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tspoc_pkg::WORD_W-1:0]    cmd_word0,
  output logic [tspoc_pkg::WORD_W-1:0]    cmd_word1,
  output logic [tspoc_pkg::COUNT_W-1:0]   cmd_word2,
  output logic [tspoc_pkg::COUNT_W-1:0]   cmd_word3
);
  import tspoc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PEND
  } state_t;

  state_t state;

  // Configuration registers.
  logic               pcr_correct_enable;
  logic [WORD_W-1:0]  pcr_offset_base;
  logic [EXT_W-1:0]   pcr_offset_ext;
  logic [LIMIT_W-1:0] remap_count;
  logic               cc_restamp_enable;

  // Counters and per-packet context.
  logic [COUNT_W-1:0] packet_count;
  logic [CC_W-1:0]    continuity_count;
  logic               restamp_pcr;
  logic [CC_W-1:0]    cc_value;
  logic [COUNT_W-1:0] count_value;
  logic               res_hit;
  logic [PID_W-1:0]   res_pid;

  logic      accept;
  logic      packet_accept;
  logic      out_free;
  logic      pcr_now;
  entry_wr_t entry_wr;
  link_t     head;
  link_t     tail;

  assign in_ready      = (state == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign packet_accept = accept && (opcode == OP_PACKET);
  assign out_free      = !out_valid || out_ready;

  // PCR restamp condition for the incoming header.
  assign pcr_now = pcr_correct_enable && header_word[AF_EXISTS_BIT]
                   && (adaptation_word[WORD_W-1:AF_LEN_LSB] != '0)
                   && adaptation_word[PCR_FLAG_BIT];

  // Load items write the remap table directly.
  always_comb begin
    entry_wr.we          = accept && (opcode == OP_LOAD);
    entry_wr.index       = entry_index;
    entry_wr.match_pid   = match_pid;
    entry_wr.replace_pid = replace_pid;
  end

  // Packet items launch a query into the cell row.
  always_comb begin
    head.valid   = packet_accept;
    head.pid     = header_word[PID_LSB +: PID_W];
    head.hit     = 1'b0;
    head.new_pid = '0;
  end

  tspoc_chain #(
    .REMAP_ENTRIES(REMAP_ENTRIES)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .entry_wr   (entry_wr),
    .remap_count(remap_count),
    .head       (head),
    .tail       (tail)
  );

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pcr_correct_enable <= 1'b1;
      pcr_offset_base    <= '0;
      pcr_offset_ext     <= '0;
      remap_count        <= LIMIT_W'(1);
      cc_restamp_enable  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PCR_CORRECT_ENABLE: pcr_correct_enable <= cfg_data[0];
        REG_PCR_OFFSET_BASE:    pcr_offset_base    <= cfg_data;
        REG_PCR_OFFSET_EXT:     pcr_offset_ext     <= cfg_data[EXT_W-1:0];
        REG_REMAP_COUNT:        remap_count        <= cfg_data[LIMIT_W-1:0];
        REG_CC_RESTAMP_ENABLE:  cc_restamp_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Counters advance once per packet; the command carries the old values.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_count     <= '0;
      continuity_count <= '0;
    end else if (packet_accept) begin
      packet_count     <= packet_count + COUNT_W'(1);
      continuity_count <= continuity_count + CC_W'(1);
    end
    if (packet_accept) begin
      restamp_pcr <= pcr_now;
      cc_value    <= continuity_count;
      count_value <= packet_count;
    end
  end

  // Control: scan the cell row, hold the result, then load the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_PEND && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (packet_accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail.valid) begin
            state <= ST_PEND;
          end
        end
        ST_PEND: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    if (state == ST_SCAN && tail.valid) begin
      res_hit <= tail.hit;
      res_pid <= tail.new_pid;
    end
    if (state == ST_PEND && out_free) begin
      cmd_word0 <= {cc_restamp_enable, res_hit, restamp_pcr,
                    (res_hit ? res_pid : {PID_W{1'b0}}),
                    CMD_FIXED_BITS,
                    (cc_restamp_enable ? cc_value : {CC_W{1'b0}}),
                    (restamp_pcr ? pcr_offset_ext : {EXT_W{1'b0}})};
      cmd_word1 <= restamp_pcr ? pcr_offset_base : {WORD_W{1'b0}};
      cmd_word2 <= count_value;
      cmd_word3 <= count_value;
    end
  end

  // A query only leaves the cell row while the controller waits for it.
  assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state == ST_SCAN))
    else $error("query left the cell row outside a scan");

  // A packet item closes the input until its command is issued.
  assert property (@(posedge clk) disable iff (rst)
    packet_accept |=> !in_ready)
    else $error("input reopened while a packet item is in work");

  // The packet count steps by one for each packet item.
  assert property (@(posedge clk) disable iff (rst)
    packet_accept |=> (packet_count == $past(packet_count) + COUNT_W'(1)))
    else $error("packet count did not advance");

endmodule

// ===== rtl/tspoc_cell.sv =====
// One remap table entry with its compare stage in the search chain.
// Depends on tspoc_pkg for the link and entry write types.
module tspoc_cell #(
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tspoc_pkg::entry_wr_t       entry_wr,
  input  logic [tspoc_pkg::LIMIT_W-1:0] remap_count,
  input  tspoc_pkg::link_t           link_in,
  output tspoc_pkg::link_t           link_out
);
  import tspoc_pkg::*;

  logic [PID_W-1:0] source_pid;
  logic [PID_W-1:0] target_pid;
  logic             active;
  logic             match;

  // This entry is scanned only when it lies below the programmed count.
  assign active = ({{(32-LIMIT_W){1'b0}}, remap_count} > 32'(INDEX));
  assign match  = active && !link_in.hit && (source_pid == link_in.pid);

  // Entry storage, written by load items addressed to this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_pid <= PID_RESET;
      target_pid <= PID_RESET;
    end else if (entry_wr.we && ({{(32-INDEX_W){1'b0}}, entry_wr.index} == 32'(INDEX))) begin
      source_pid <= entry_wr.match_pid;
      target_pid <= entry_wr.replace_pid;
    end
  end

  // Pass the query on; the first matching cell claims it.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else begin
      link_out.valid <= link_in.valid;
    end
    link_out.pid <= link_in.pid;
    if (match) begin
      link_out.hit     <= 1'b1;
      link_out.new_pid <= target_pid;
    end else begin
      link_out.hit     <= link_in.hit;
      link_out.new_pid <= link_in.new_pid;
    end
  end

endmodule

// ===== rtl/tspoc_chain.sv =====
// Row of remap cells; a query enters at cell 0 and leaves after the last cell.
// Depends on tspoc_pkg and tspoc_cell.
module tspoc_chain #(
  parameter int REMAP_ENTRIES = tspoc_pkg::REMAP_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tspoc_pkg::entry_wr_t          entry_wr,
  input  logic [tspoc_pkg::LIMIT_W-1:0] remap_count,
  input  tspoc_pkg::link_t              head,
  output tspoc_pkg::link_t              tail
);
  import tspoc_pkg::*;

  link_t links [REMAP_ENTRIES+1];

  assign links[0] = head;

  // One cell per table entry, each feeding the next.
  for (genvar i = 0; i < REMAP_ENTRIES; i++) begin : g_cell
    tspoc_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .entry_wr   (entry_wr),
      .remap_count(remap_count),
      .link_in    (links[i]),
      .link_out   (links[i+1])
    );
  end

  assign tail = links[REMAP_ENTRIES];

endmodule
